### design/u8rdq_pkg.sv
// shared types, constants and utf-8 codec functions for the code point ring deque
// no dependencies; imported by u8rdq_store, u8rdq_ctrl and utf8_code_point_ring_deque

package u8rdq_pkg;

    // byte store depth; pointers wrap by their natural width, so a power of two
    localparam int CAPACITY = 256;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int MAX_UNITS = 4;
    localparam int FILL_W   = 9;
    localparam int CP_W     = 21;
    localparam int LEN_W    = 3;

    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

    // command codes
    localparam logic [1:0] CMD_PUSH_HEAD = 2'd0;
    localparam logic [1:0] CMD_PUSH_TAIL = 2'd1;
    localparam logic [1:0] CMD_POP_HEAD  = 2'd2;
    localparam logic [1:0] CMD_POP_TAIL  = 2'd3;

    typedef logic [MAX_UNITS-1:0][7:0] byte4_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        byte4_t           bytes;
    } enc_t;

    typedef struct packed {
        logic            ok;
        logic [CP_W-1:0] cp;
    } dec_t;

    // one write port and one read port of the byte store
    typedef struct packed {
        logic             wr_en;
        logic [PTR_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [PTR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // sequence length announced by a lead byte, zero for a bad lead
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] n;
        if (b < 8'h80)      n = 3'd1;
        else if (b < 8'hC2) n = 3'd0;
        else if (b < 8'hE0) n = 3'd2;
        else if (b < 8'hF0) n = 3'd3;
        else if (b < 8'hF5) n = 3'd4;
        else                n = 3'd0;
        return n;
    endfunction

    function automatic enc_t encode_cp(input logic [CP_W-1:0] cp);
        enc_t e;
        e.len   = '0;
        e.bytes = '0;
        if (cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
            e.len = 3'd0;
        end
        else if (cp < 21'h80) begin
            e.len      = 3'd1;
            e.bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h800) begin
            e.len      = 3'd2;
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            e.len      = 3'd3;
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            e.len      = 3'd4;
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
        end
        return e;
    endfunction

    // checks and decodes len bytes, lead byte first
    function automatic dec_t decode_seq(input byte4_t b, input logic [LEN_W-1:0] len);
        dec_t            d;
        logic            good;
        logic [CP_W-1:0] v;
        good = (len != 3'd0) && (lead_length(b[0]) == len);
        for (int i = 1; i < MAX_UNITS; i++) begin
            if ((LEN_W'(i) < len) && !is_cont(b[i])) begin
                good = 1'b0;
            end
        end
        unique case (len)
            3'd1:    v = {14'd0, b[0][6:0]};
            3'd2:    v = {10'd0, b[0][4:0], b[1][5:0]};
            3'd3:    v = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
            3'd4:    v = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
            default: v = '0;
        endcase
        // overlong forms, surrogates and values past the unicode range
        if (len == 3'd2 && v < 21'h80)    good = 1'b0;
        if (len == 3'd3 && v < 21'h800)   good = 1'b0;
        if (len == 3'd4 && v < 21'h10000) good = 1'b0;
        if (v > CP_MAX)                   good = 1'b0;
        if (v >= SURR_LO && v <= SURR_HI) good = 1'b0;
        d.ok = good;
        d.cp = good ? v : '0;
        return d;
    endfunction

endpackage

### design/u8rdq_store.sv
// byte store of the deque: synchronous ram, one write and one read port
// depends on u8rdq_pkg for depth and the request struct

module u8rdq_store
    import u8rdq_pkg::*;
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [CAPACITY];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/u8rdq_ctrl.sv
// sequencer of the deque: pointers, byte count, store access and result register
// depends on u8rdq_pkg; drives the byte store through a mem_req_t

module u8rdq_ctrl
    import u8rdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [CP_W-1:0]   code_point_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [LEN_W-1:0]  units_moved,
    output logic [CP_W-1:0]   code_point_out,
    output logic [FILL_W-1:0] fill_level,
    output mem_req_t          mem_req,
    input  logic [7:0]        mem_rd_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        cmd_reg;
    logic [LEN_W-1:0]  enc_len_reg;
    byte4_t            enc_bytes_reg;
    logic              push_ok_reg;
    logic [PTR_W-1:0]  base_reg;
    logic [1:0]        idx_reg;
    logic              cap_vld_reg;
    logic [1:0]        cap_idx_reg;
    byte4_t            bytes_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg;
    logic              ok_reg;
    logic [LEN_W-1:0]  units_reg;
    logic [CP_W-1:0]   cp_out_reg;
    logic [FILL_W-1:0] fill_reg;

    logic              accept;
    logic              out_free;
    logic              commit;
    enc_t              enc;
    logic              fits;

    logic              res_ok;
    logic [LEN_W-1:0]  res_len;
    logic [CP_W-1:0]   res_cp;
    dec_t              dec_head;
    dec_t              dec_tail;
    logic [LEN_W-1:0]  head_len;
    logic              tail_found;
    logic              tail_stop;
    logic [1:0]        tail_trail;
    byte4_t            tail_fw;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_EVAL) && out_free;

    assign enc  = encode_cp(code_point_in);
    assign fits = (enc.len != '0) &&
        (({1'b0, count_reg} + (CNT_W+1)'(enc.len)) <= (CNT_W+1)'(CAPACITY));

    // store access
    always_comb
    begin
        mem_req         = '0;
        mem_req.wr_addr = base_reg + PTR_W'(idx_reg);
        mem_req.wr_data = enc_bytes_reg[idx_reg];
        mem_req.rd_addr = (cmd_reg == CMD_POP_TAIL) ? (base_reg - PTR_W'(idx_reg))
                                                    : (base_reg + PTR_W'(idx_reg));
        mem_req.wr_en   = (state_reg == S_WR);
        mem_req.rd_en   = (state_reg == S_RD);
    end

    // head pop: lead byte gives the length
    always_comb
    begin
        head_len = lead_length(bytes_reg[0]);
        dec_head = decode_seq(bytes_reg, head_len);
    end

    // tail pop: bytes_reg[k] holds the byte k+1 places before the tail
    always_comb
    begin
        tail_found = 1'b0;
        tail_stop  = 1'b0;
        tail_trail = '0;
        tail_fw    = '0;
        for (int k = 0; k < MAX_UNITS; k++)
        begin
            if (!tail_stop)
            begin
                if (CNT_W'(k) >= count_reg)
                begin
                    tail_stop = 1'b1;
                end
                else if (!is_cont(bytes_reg[k]))
                begin
                    tail_found = 1'b1;
                    tail_trail = 2'(k);
                    tail_stop  = 1'b1;
                end
            end
        end
        for (int j = 0; j < MAX_UNITS; j++)
        begin
            if (2'(j) <= tail_trail)
            begin
                tail_fw[j] = bytes_reg[tail_trail - 2'(j)];
            end
        end
        dec_tail = decode_seq(tail_fw, LEN_W'(tail_trail) + 3'd1);
    end

    // outcome of the item and the pointer update it causes
    always_comb
    begin
        res_ok     = 1'b0;
        res_len    = '0;
        res_cp     = '0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case (cmd_reg)
            CMD_PUSH_HEAD:
            begin
                res_ok = push_ok_reg;
                if (push_ok_reg)
                begin
                    res_len    = enc_len_reg;
                    head_next  = base_reg;
                    count_next = count_reg + CNT_W'(enc_len_reg);
                end
            end
            CMD_PUSH_TAIL:
            begin
                res_ok = push_ok_reg;
                if (push_ok_reg)
                begin
                    res_len    = enc_len_reg;
                    tail_next  = tail_reg + PTR_W'(enc_len_reg);
                    count_next = count_reg + CNT_W'(enc_len_reg);
                end
            end
            CMD_POP_HEAD:
            begin
                if (count_reg != '0 && CNT_W'(head_len) <= count_reg && dec_head.ok)
                begin
                    res_ok     = 1'b1;
                    res_len    = head_len;
                    res_cp     = dec_head.cp;
                    head_next  = head_reg + PTR_W'(head_len);
                    count_next = count_reg - CNT_W'(head_len);
                end
            end
            CMD_POP_TAIL:
            begin
                if (tail_found && dec_tail.ok)
                begin
                    res_ok     = 1'b1;
                    res_len    = LEN_W'(tail_trail) + 3'd1;
                    res_cp     = dec_tail.cp;
                    tail_next  = tail_reg - PTR_W'(tail_trail) - PTR_W'(1);
                    count_next = count_reg - CNT_W'(tail_trail) - CNT_W'(1);
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_PUSH_HEAD || command == CMD_PUSH_TAIL)
                        state_next = fits ? S_WR : S_EVAL;
                    else
                        state_next = (count_reg != '0) ? S_RD : S_EVAL;
                end
            end
            S_WR:    state_next = (LEN_W'(idx_reg) + 3'd1 == enc_len_reg) ? S_EVAL : S_WR;
            S_RD:    state_next = (idx_reg == 2'd3) ? S_WAIT : S_RD;
            S_WAIT:  state_next = S_EVAL;
            S_EVAL:  state_next = out_free ? S_IDLE : S_EVAL;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            cap_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cap_vld_reg <= (state_reg == S_RD);
            if (commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload, read capture and result fields
    always_ff @(posedge clk)
    begin
        cap_idx_reg <= idx_reg;
        if (accept)
        begin
            cmd_reg       <= command;
            enc_len_reg   <= enc.len;
            enc_bytes_reg <= enc.bytes;
            push_ok_reg   <= fits;
            idx_reg       <= '0;
            if (command == CMD_PUSH_HEAD)
                base_reg <= head_reg - PTR_W'(enc.len);
            else if (command == CMD_POP_TAIL)
                base_reg <= tail_reg - PTR_W'(1);
            else if (command == CMD_POP_HEAD)
                base_reg <= head_reg;
            else
                base_reg <= tail_reg;
        end
        else if (state_reg == S_WR || state_reg == S_RD)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
        if (cap_vld_reg)
        begin
            bytes_reg[cap_idx_reg] <= mem_rd_data;
        end
        if (commit)
        begin
            ok_reg     <= res_ok;
            units_reg  <= res_len;
            cp_out_reg <= res_cp;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign units_moved    = units_reg;
    assign code_point_out = cp_out_reg;
    assign fill_level     = fill_reg;

endmodule

### design/utf8_code_point_ring_deque.sv
// top level of the utf-8 code point ring deque
// depends on u8rdq_pkg, u8rdq_store and u8rdq_ctrl

// A double-ended queue of unicode code points held as utf-8 in a 256-byte
// circular store. Each input transaction pushes a code point at the head or
// tail, or pops one from the head or tail, and gives exactly one result
// transaction: ok, bytes moved, the popped code point and the fill level.
// Invalid code points, pushes without room, empty pops and malformed or
// truncated sequences are refused with the state unchanged. One item is
// worked at a time through the synchronous byte store (one write and one
// read port): a push writes its encoded bytes one byte per cycle, a pop
// reads four bytes one byte per cycle and waits for the read data, then
// the item is evaluated; a refused push or a pop on an empty deque goes
// straight to evaluation. The store needs no clearing after reset. A finished
// result sits in the output register while the next item is accepted; the
// block only stalls when a second result is ready before the first is taken.

module utf8_code_point_ring_deque
    import u8rdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [CP_W-1:0]   code_point_in,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [LEN_W-1:0]  units_moved,
    output logic [CP_W-1:0]   code_point_out,
    output logic [FILL_W-1:0] fill_level
);

    // store request from the sequencer, read data back in the next cycle
    mem_req_t   mem_req;
    logic [7:0] mem_rd_data;

    // pointers, count and the per-item sequence
    u8rdq_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .code_point_in  (code_point_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .units_moved    (units_moved),
        .code_point_out (code_point_out),
        .fill_level     (fill_level),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data)
    );

    // byte store; writes and reads never share a cycle, so no forwarding
    u8rdq_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // a refused transaction reports nothing moved and no code point
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (units_moved == '0 && code_point_out == '0))
    else $error("refused result carries data");

    // a carried-out transaction moves one to four bytes of a legal code point
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ok) |-> (units_moved != '0 && units_moved <= 3'd4 &&
                               code_point_out <= CP_MAX))
    else $error("bad length or code point on success");

    // one item at a time: the input closes right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in work");

    // fill level never passes the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_level <= FILL_W'(CAPACITY)))
    else $error("fill level beyond capacity");

endmodule
